// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file lrbc_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/lrbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lrbc_pkg
// Types, codes and reset constants of the link retry backoff controller.
// ----------------------------------------------------------------------------
package lrbc_pkg;

    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [23:0] INIT_BACKOFF_RST  = 24'd100;
    localparam logic [23:0] MAX_BACKOFF_RST   = 24'd10000;
    localparam logic [15:0] GROWTH_RST        = 16'd8192;
    localparam logic [15:0] ATTEMPT_LIMIT_RST = 16'd0;

    localparam logic [15:0] ATTEMPTS_FULL = 16'hFFFF;
    localparam logic [39:0] RAW_SAT       = 40'hFF_FFFF_FFFF;

    // phase codes as seen on the result channel
    localparam logic [2:0] LINK_IDLE       = 3'd0;
    localparam logic [2:0] LINK_WAITING    = 3'd1;
    localparam logic [2:0] LINK_ATTEMPTING = 3'd2;
    localparam logic [2:0] LINK_CONNECTED  = 3'd3;
    localparam logic [2:0] LINK_EXHAUSTED  = 3'd4;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_WAITING    = 5'b00010,
        PH_ATTEMPTING = 5'b00100,
        PH_CONNECTED  = 5'b01000,
        PH_EXHAUSTED  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        MODE_TICK      = 2'd0,
        MODE_CONNECTED = 2'd1,
        MODE_FAILED    = 2'd2,
        MODE_RESET     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_INITIAL_BACKOFF = 2'd0,
        REG_MAX_BACKOFF     = 2'd1,
        REG_GROWTH          = 2'd2,
        REG_ATTEMPT_LIMIT   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       attempt_ok;
    } lrbc_in_t;

    typedef struct packed {
        logic [23:0] wait_ms;
        logic [2:0]  link_phase;
        logic [15:0] attempt_count;
    } lrbc_out_t;

    typedef struct packed {
        logic [23:0] initial_backoff_ms;
        logic [23:0] max_backoff_ms;
        logic [15:0] growth_factor;
        logic [15:0] attempt_limit;
    } lrbc_cfg_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        unique case (ph)
            PH_IDLE:       code = LINK_IDLE;
            PH_WAITING:    code = LINK_WAITING;
            PH_ATTEMPTING: code = LINK_ATTEMPTING;
            PH_CONNECTED:  code = LINK_CONNECTED;
            PH_EXHAUSTED:  code = LINK_EXHAUSTED;
            default:       code = LINK_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/lrbc_cfg.sv =====
// ----------------------------------------------------------------------------
// lrbc_cfg
// APB register file holding the backoff configuration.
// ----------------------------------------------------------------------------
module lrbc_cfg
    import lrbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output lrbc_cfg_t             cfg
);

    lrbc_cfg_t cfg_reg;
    logic      wr_en;
    reg_idx_t  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_backoff_ms <= INIT_BACKOFF_RST;
            cfg_reg.max_backoff_ms     <= MAX_BACKOFF_RST;
            cfg_reg.growth_factor      <= GROWTH_RST;
            cfg_reg.attempt_limit      <= ATTEMPT_LIMIT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_INITIAL_BACKOFF: cfg_reg.initial_backoff_ms <= pwdata[23:0];
                REG_MAX_BACKOFF:     cfg_reg.max_backoff_ms     <= pwdata[23:0];
                REG_GROWTH:          cfg_reg.growth_factor      <= pwdata[15:0];
                REG_ATTEMPT_LIMIT:   cfg_reg.attempt_limit      <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_INITIAL_BACKOFF: prdata = {8'd0, cfg_reg.initial_backoff_ms};
            REG_MAX_BACKOFF:     prdata = {8'd0, cfg_reg.max_backoff_ms};
            REG_GROWTH:          prdata = {16'd0, cfg_reg.growth_factor};
            REG_ATTEMPT_LIMIT:   prdata = {16'd0, cfg_reg.attempt_limit};
        endcase
    end

endmodule

// ===== sv/lrbc_core.sv =====
// ----------------------------------------------------------------------------
// lrbc_core
// Input register, phase machine with backoff product, and result register.
// ----------------------------------------------------------------------------
module lrbc_core
    import lrbc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  lrbc_cfg_t cfg,
    input  logic      s_valid,
    output logic      s_ready,
    input  lrbc_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output lrbc_out_t m_data
);

    logic      in_v_reg;
    lrbc_in_t  in_reg;
    logic      out_v_reg;
    lrbc_out_t out_reg;

    phase_t      phase_reg,   phase_next;
    logic [15:0] attempts_reg, attempts_next;
    logic [23:0] backoff_reg, backoff_next;
    logic [39:0] raw_reg,     raw_next;
    logic [23:0] wait_next;

    logic        advance;
    logic        fire;

    logic [15:0] attempts_inc;
    logic [55:0] prod_full;
    logic [43:0] prod_shift;
    logic [39:0] fail_raw;
    logic [23:0] fail_int;
    logic [23:0] fail_backoff;
    logic        give_up;

    assign advance = !out_v_reg || m_ready;
    assign fire    = in_v_reg && advance;
    assign s_ready = !in_v_reg || advance;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // failure path: counter, running product, clamp
    assign attempts_inc = (attempts_reg == ATTEMPTS_FULL) ? attempts_reg : attempts_reg + 16'd1;
    assign prod_full    = 56'(raw_reg) * 56'(cfg.growth_factor);
    assign prod_shift   = prod_full[55:12];
    assign fail_raw     = (attempts_inc <= 16'd1) ? {cfg.initial_backoff_ms, 16'd0}
                        : (|prod_shift[43:40])    ? RAW_SAT
                        :                           prod_shift[39:0];
    assign fail_int     = fail_raw[39:16];
    assign fail_backoff = (fail_int > cfg.max_backoff_ms) ? cfg.max_backoff_ms : fail_int;
    assign give_up      = (cfg.attempt_limit != 16'd0) && (attempts_inc >= cfg.attempt_limit);

    always_comb begin
        phase_next    = phase_reg;
        attempts_next = attempts_reg;
        backoff_next  = backoff_reg;
        raw_next      = raw_reg;
        wait_next     = 24'd0;
        unique case (mode_t'(in_reg.mode))
            MODE_TICK: begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        attempts_next = 16'd0;
                        backoff_next  = cfg.initial_backoff_ms;
                        phase_next    = PH_WAITING;
                    end
                    PH_WAITING: begin
                        wait_next  = backoff_reg;
                        phase_next = PH_ATTEMPTING;
                    end
                    PH_ATTEMPTING: begin
                        attempts_next = attempts_inc;
                        priority if (in_reg.attempt_ok) begin
                            phase_next = PH_CONNECTED;
                        end else if (give_up) begin
                            phase_next = PH_EXHAUSTED;
                        end else begin
                            raw_next     = fail_raw;
                            backoff_next = fail_backoff;
                            phase_next   = PH_WAITING;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_CONNECTED: begin
                phase_next    = PH_CONNECTED;
                attempts_next = 16'd0;
                backoff_next  = cfg.initial_backoff_ms;
            end
            MODE_FAILED: begin
                if (phase_reg == PH_CONNECTED) begin
                    phase_next = PH_WAITING;
                end
            end
            MODE_RESET: begin
                phase_next    = PH_IDLE;
                attempts_next = 16'd0;
                backoff_next  = cfg.initial_backoff_ms;
                raw_next      = {cfg.initial_backoff_ms, 16'd0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            phase_reg    <= PH_IDLE;
            attempts_reg <= 16'd0;
            backoff_reg  <= INIT_BACKOFF_RST;
            raw_reg      <= {INIT_BACKOFF_RST, 16'd0};
        end else begin
            if (s_valid && s_ready) begin
                in_v_reg <= 1'b1;
            end else if (fire) begin
                in_v_reg <= 1'b0;
            end
            if (fire) begin
                out_v_reg    <= 1'b1;
                phase_reg    <= phase_next;
                attempts_reg <= attempts_next;
                backoff_reg  <= backoff_next;
                raw_reg      <= raw_next;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            out_reg.wait_ms       <= wait_next;
            out_reg.link_phase    <= phase_code(phase_next);
            out_reg.attempt_count <= attempts_next;
        end
    end

endmodule

// ===== sv/link_retry_backoff_controller.sv =====
// ----------------------------------------------------------------------------
// link_retry_backoff_controller
// Link retry phase machine with exponential backoff and an APB config port.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one event request (mode, attempt_ok) each.
//   m_valid/m_ready/m_data return exactly one result per event: wait_ms,
//   link_phase after the event and the attempt count.
//   The accepting edge loads the input register; the result register loads from
//   it through the phase and backoff logic when free or m_ready is high.
//   One event per cycle is sustained while m_ready is high; the multiply,
//   saturate and clamp of the running product fit in the same cycle as the
//   phase update. When m_ready is low the result register holds and the
//   input register can still take one more request; s_ready drops only when
//   both are full and m_ready is low. m_valid rises with each result load.
//   Reset (aresetn low, synchronous) empties both registers, sets the phase to
//   idle, the attempt count to zero, the backoff to 100 ms and restores all
//   configuration registers to their defaults.
//   The user must write configuration over APB at byte addresses 0, 4, 8 and 12
//   while no event is in flight, unenforced by the block; pready is always high.
// ----------------------------------------------------------------------------
module link_retry_backoff_controller
    import lrbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lrbc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lrbc_out_t             m_data
);

    lrbc_cfg_t cfg;

    lrbc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lrbc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/lrbc_checker.sv =====
// ----------------------------------------------------------------------------
// lrbc_checker
// Port-level checks of the retry controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrbc_checker
    import lrbc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input lrbc_out_t m_data
);

    // a stalled result holds its contents
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")

    // a wait is only reported on the move into attempting
    `ASSERT_CLK(a_wait_phase, aclk, aresetn, m_valid && m_data.wait_ms != 24'd0 |-> m_data.link_phase == LINK_ATTEMPTING, "nonzero wait outside attempting")

    // idle is only reached by a forced reset, which clears the count and the wait
    `ASSERT_CLK(a_idle_clear, aclk, aresetn, m_valid && m_data.link_phase == LINK_IDLE |-> m_data.attempt_count == 16'd0 && m_data.wait_ms == 24'd0, "idle result with state left")

    // reset empties the pipeline
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_valid && s_ready, "pipeline not empty after reset")

    // with the result side free the block never refuses a request
    `ASSERT_CLK(a_no_stall, aclk, aresetn, !m_valid && s_valid |-> s_ready, "request refused with empty output")

endmodule

bind link_retry_backoff_controller lrbc_checker u_lrbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
